/* hw/rtl/tbr_pkg.sv */
// ----------------------------------------------------------------------------
// tbr_pkg
// Shared widths, register codes and small helpers for the barycentric
// triangle rasterizer.
// ----------------------------------------------------------------------------
package tbr_pkg;

  // Pixel and vertex coordinate width.
  localparam int COORD_BITS = 10;

  // Edge coefficient (difference of two coordinates), signed.
  localparam int COEF_W  = COORD_BITS + 1;
  // Product of two unsigned coordinates.
  localparam int PROD_W  = 2 * COORD_BITS;
  // Constant edge term, signed difference of two products.
  localparam int CONST_W = PROD_W + 1;
  // Coefficient times pixel coordinate, signed.
  localparam int TERM_W  = 2 * COORD_BITS + 2;
  // Full edge function value, signed.
  localparam int EDGE_W  = 2 * COORD_BITS + 3;
  // Magnitude of an edge value.
  localparam int MAG_W   = EDGE_W - 1;
  // Colour channel width and the restoring divider built on it.
  localparam int COLOR_W = 8;
  localparam int DIV_W   = MAG_W + COLOR_W;

  // Pixel pipeline: five front stages, then one divider step per colour bit.
  localparam int FRONT_STAGES = 5;
  localparam int DIV_STAGES   = COLOR_W;
  localparam int NUM_STAGES   = FRONT_STAGES + DIV_STAGES;

  // Configuration register codes.
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_V0_X = 3'd0,
    REG_V0_Y = 3'd1,
    REG_V1_X = 3'd2,
    REG_V1_Y = 3'd3,
    REG_V2_X = 3'd4,
    REG_V2_Y = 3'd5
  } cfg_reg_t;

  typedef logic [COORD_BITS-1:0]    coord_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [TERM_W-1:0] term_t;
  typedef logic signed [EDGE_W-1:0] edge_t;

  // Signed coefficient times an unsigned coordinate.
  function automatic term_t mul_term(input coef_t coef, input coord_t coord);
    term_t a;
    term_t b;
    a = TERM_W'(coef);
    b = $signed(TERM_W'({1'b0, coord}));
    return a * b;
  endfunction

  function automatic coord_t min3(input coord_t a, input coord_t b, input coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (c < m) ? c : m;
  endfunction

  function automatic coord_t max3(input coord_t a, input coord_t b, input coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (c > m) ? c : m;
  endfunction

endpackage

/* hw/rtl/triangle_barycentric_raster.sv */
// ----------------------------------------------------------------------------
// triangle_barycentric_raster
// Per-pixel coverage test and barycentric colour for one triangle.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock while in_stall is low and returns one result
// word per pixel, in order. The 13 register stages are: input capture, edge
// products, edge sums, sign and magnitude, coverage decision with the 255x
// dividend, and eight restoring divider steps (one colour bit each, three
// lanes side by side); the last divider step is the output register. Stalls
// are absorbed stage by stage, so empty stages keep filling while a result
// waits. Values derived from the vertex registers (edge coefficients, constant
// terms, twice the area and its magnitude) pass through their own four
// register stages; a pixel may follow a vertex write from the next cycle on.
// ----------------------------------------------------------------------------
module triangle_barycentric_raster
  import tbr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_wdata,
  // Pixel input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_pixel_x,
  input  logic [COORD_BITS-1:0] in_pixel_y,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic                  out_drawn,
  output logic [COLOR_W-1:0]    out_red,
  output logic [COLOR_W-1:0]    out_green,
  output logic [COLOR_W-1:0]    out_blue
);

  // --------------------------------------------------------------------------
  // Vertex registers
  // --------------------------------------------------------------------------
  coord_t vx_r [3];
  coord_t vy_r [3];

  // A write to an index past the last register is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        vx_r[i] <= '0;
        vy_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_V0_X: vx_r[0] <= cfg_wdata;
        REG_V0_Y: vy_r[0] <= cfg_wdata;
        REG_V1_X: vx_r[1] <= cfg_wdata;
        REG_V1_Y: vy_r[1] <= cfg_wdata;
        REG_V2_X: vx_r[2] <= cfg_wdata;
        REG_V2_Y: vy_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Setup stage A: edge coefficients, vertex products, bounding box
  // --------------------------------------------------------------------------
  coef_t               coef_a_r [3];
  coef_t               coef_b_r [3];
  logic [PROD_W-1:0]   prod_p_r [3];
  logic [PROD_W-1:0]   prod_n_r [3];
  coord_t              xmin_r;
  coord_t              xmax_r;
  coord_t              ymin_r;
  coord_t              ymax_r;

  // Edge i runs between the other two vertices j and k, taken cyclically.
  for (genvar gi = 0; gi < 3; gi++) begin : g_edge_setup
    localparam int J = (gi + 1) % 3;
    localparam int K = (gi + 2) % 3;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        coef_a_r[gi] <= '0;
        coef_b_r[gi] <= '0;
        prod_p_r[gi] <= '0;
        prod_n_r[gi] <= '0;
      end else begin
        coef_a_r[gi] <= $signed({1'b0, vy_r[J]}) - $signed({1'b0, vy_r[K]});
        coef_b_r[gi] <= $signed({1'b0, vx_r[K]}) - $signed({1'b0, vx_r[J]});
        prod_p_r[gi] <= PROD_W'(vx_r[J]) * PROD_W'(vy_r[K]);
        prod_n_r[gi] <= PROD_W'(vx_r[K]) * PROD_W'(vy_r[J]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xmin_r <= '0;
      xmax_r <= '0;
      ymin_r <= '0;
      ymax_r <= '0;
    end else begin
      xmin_r <= min3(vx_r[0], vx_r[1], vx_r[2]);
      xmax_r <= max3(vx_r[0], vx_r[1], vx_r[2]);
      ymin_r <= min3(vy_r[0], vy_r[1], vy_r[2]);
      ymax_r <= max3(vy_r[0], vy_r[1], vy_r[2]);
    end
  end

  // --------------------------------------------------------------------------
  // Setup stage B: constant term of each edge function
  // --------------------------------------------------------------------------
  logic signed [CONST_W-1:0] const_c_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) const_c_r[i] <= '0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        const_c_r[i] <= $signed({1'b0, prod_p_r[i]}) - $signed({1'b0, prod_n_r[i]});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Setup stage C: twice the signed area, and each edge at the point (-1,-1)
  // --------------------------------------------------------------------------
  edge_t area_r;
  edge_t eoff_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r <= '0;
      for (int i = 0; i < 3; i++) eoff_r[i] <= '0;
    end else begin
      area_r <= EDGE_W'(const_c_r[0]) + EDGE_W'(const_c_r[1]) + EDGE_W'(const_c_r[2]);
      for (int i = 0; i < 3; i++) begin
        eoff_r[i] <= EDGE_W'(const_c_r[i]) - EDGE_W'(coef_a_r[i]) - EDGE_W'(coef_b_r[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Setup stage D: area sign, divisor, tie-break flags for zero weights
  // --------------------------------------------------------------------------
  logic             area_pos_r;
  logic             area_neg_r;
  logic [MAG_W-1:0] den_r;
  logic [2:0]       off_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_pos_r <= 1'b0;
      area_neg_r <= 1'b0;
      den_r      <= '0;
      off_ok_r   <= '0;
    end else begin
      area_pos_r <= !area_r[EDGE_W-1] && (area_r != '0);
      area_neg_r <= area_r[EDGE_W-1];
      den_r      <= area_r[EDGE_W-1] ? MAG_W'(-area_r) : MAG_W'(area_r);
      // A zero weight counts only when (-1,-1) sits strictly on the area's side.
      for (int i = 0; i < 3; i++) begin
        off_ok_r[i] <= (eoff_r[i] != '0) && (area_r != '0)
                       && (eoff_r[i][EDGE_W-1] == area_r[EDGE_W-1]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pixel pipeline flow control
  // --------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] adv;

  // A stage may load unless it and every stage after it are full and the
  // output is stalled.
  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      adv[k] = !out_stall
               || ((vld_r | ((NUM_STAGES'(1) << k) - NUM_STAGES'(1))) != '1);
    end
  end

  assign vld_nxt  = {vld_r[NUM_STAGES-2:0], in_valid};
  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (adv[k]) vld_r[k] <= vld_nxt[k];
      end
    end
  end

  // Pixel coordinates travel along with every stage.
  coord_t px_r [NUM_STAGES];
  coord_t py_r [NUM_STAGES];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      px_r[0] <= in_pixel_x;
      py_r[0] <= in_pixel_y;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (adv[k]) begin
        px_r[k] <= px_r[k-1];
        py_r[k] <= py_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: edge products and bounding-box test (half-open box)
  // --------------------------------------------------------------------------
  term_t term_a_r [3];
  term_t term_b_r [3];
  logic  box1_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        term_a_r[i] <= mul_term(coef_a_r[i], px_r[0]);
        term_b_r[i] <= mul_term(coef_b_r[i], py_r[0]);
      end
      box1_r <= (px_r[0] >= xmin_r) && (px_r[0] < xmax_r)
                && (py_r[0] >= ymin_r) && (py_r[0] < ymax_r);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: edge function values
  // --------------------------------------------------------------------------
  edge_t edge_r [3];
  logic  box2_r;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        edge_r[i] <= EDGE_W'(term_a_r[i]) + EDGE_W'(term_b_r[i]) + EDGE_W'(const_c_r[i]);
      end
      box2_r <= box1_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sign and magnitude of each edge value
  // --------------------------------------------------------------------------
  logic [2:0]       e_neg_r;
  logic [2:0]       e_zero_r;
  logic [MAG_W-1:0] mag_r [3];
  logic             box3_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < 3; i++) begin
        e_neg_r[i]  <= edge_r[i][EDGE_W-1];
        e_zero_r[i] <= (edge_r[i] == '0);
        mag_r[i]    <= edge_r[i][EDGE_W-1] ? MAG_W'(-edge_r[i]) : MAG_W'(edge_r[i]);
      end
      box3_r <= box2_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: coverage decision and dividend 255 * |E|
  // --------------------------------------------------------------------------
  logic [2:0]       weight_ok;
  logic             drawn4_r;
  logic [DIV_W-1:0] dvd_r [3];

  // A non-zero weight must share the area's sign; a zero one uses the tie-break.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      weight_ok[i] = e_zero_r[i] ? off_ok_r[i] : (e_neg_r[i] == area_neg_r);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      drawn4_r <= box3_r && (area_pos_r || area_neg_r) && (&weight_ok);
      for (int i = 0; i < 3; i++) begin
        dvd_r[i] <= {mag_r[i], COLOR_W'(0)} - DIV_W'(mag_r[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stages 5 to 12: restoring divider, one quotient bit per stage and lane.
  // The dividend is below 256 times the divisor whenever the pixel is drawn,
  // so eight bits hold the quotient. Undrawn pixels leave with zero colour.
  // --------------------------------------------------------------------------
  logic [DIV_W-1:0]   rem_r   [DIV_STAGES][3];
  logic [COLOR_W-1:0] quo_r   [DIV_STAGES][3];
  logic               drw_r   [DIV_STAGES];
  logic [DIV_W-1:0]   rem_src [DIV_STAGES][3];
  logic [COLOR_W-1:0] quo_src [DIV_STAGES][3];
  logic               drw_src [DIV_STAGES];
  logic [DIV_W-1:0]   rem_nxt [DIV_STAGES][3];
  logic [COLOR_W-1:0] quo_nxt [DIV_STAGES][3];
  logic [DIV_W-1:0]   den_sh  [DIV_STAGES];

  // Inputs of each divider step.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem_src[0][l] = dvd_r[l];
      quo_src[0][l] = '0;
    end
    drw_src[0] = drawn4_r;
    for (int s = 1; s < DIV_STAGES; s++) begin
      for (int l = 0; l < 3; l++) begin
        rem_src[s][l] = rem_r[s-1][l];
        quo_src[s][l] = quo_r[s-1][l];
      end
      drw_src[s] = drw_r[s-1];
    end
  end

  // Compare and subtract of the shifted divisor in each step.
  always_comb begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      den_sh[s] = DIV_W'(den_r) << (COLOR_W - 1 - s);
      for (int l = 0; l < 3; l++) begin
        if (rem_src[s][l] >= den_sh[s]) begin
          rem_nxt[s][l] = rem_src[s][l] - den_sh[s];
          quo_nxt[s][l] = quo_src[s][l] | (COLOR_W'(1) << (COLOR_W - 1 - s));
        end else begin
          rem_nxt[s][l] = rem_src[s][l];
          quo_nxt[s][l] = quo_src[s][l];
        end
        if ((s == DIV_STAGES - 1) && !drw_src[s]) begin
          quo_nxt[s][l] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (adv[FRONT_STAGES + s]) begin
        drw_r[s] <= drw_src[s];
        for (int l = 0; l < 3; l++) begin
          rem_r[s][l] <= rem_nxt[s][l];
          quo_r[s][l] <= quo_nxt[s][l];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result word
  // --------------------------------------------------------------------------
  assign out_valid = vld_r[NUM_STAGES-1];
  assign out_x     = px_r[NUM_STAGES-1];
  assign out_y     = py_r[NUM_STAGES-1];
  assign out_drawn = drw_r[DIV_STAGES-1];
  assign out_red   = quo_r[DIV_STAGES-1][0];
  assign out_green = quo_r[DIV_STAGES-1][1];
  assign out_blue  = quo_r[DIV_STAGES-1][2];

endmodule

/* tb/pixel_coverage_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pixel coverage checker
// Watches the vertex writes and both word channels of the rasterizer. For
// each accepted pixel word it computes the coverage flag and the barycentric
// colour with exact integer arithmetic and queues the expected result word.
// Each accepted result word is compared field by field with the oldest
// expectation.
// ----------------------------------------------------------------------------
module pixel_coverage_checker
  import tbr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [COORD_BITS-1:0] in_pixel_x,
  input  logic [COORD_BITS-1:0] in_pixel_y,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [COORD_BITS-1:0] out_x,
  input  logic [COORD_BITS-1:0] out_y,
  input  logic                  out_drawn,
  input  logic [COLOR_W-1:0]    out_red,
  input  logic [COLOR_W-1:0]    out_green,
  input  logic [COLOR_W-1:0]    out_blue,
  output int                    pending_results,
  output int                    mismatch_count
);

  typedef struct packed {
    coord_t               x;
    coord_t               y;
    logic                 drawn;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [COLOR_W-1:0]   blue;
  } shaded_pixel_t;

  longint        vert_x [3];
  longint        vert_y [3];
  shaded_pixel_t expected_pixels [$];

  // Edge function of the edge opposite vertex opp, at point (px, py).
  function automatic longint edge_at(input int opp, input longint px, input longint py);
    int j;
    int k;
    j = (opp + 1) % 3;
    k = (opp + 2) % 3;
    return (vert_y[j] - vert_y[k]) * px + (vert_x[k] - vert_x[j]) * py
         + vert_x[j] * vert_y[k] - vert_x[k] * vert_y[j];
  endfunction

  function automatic int sign_of(input longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  // Coverage and colour of one pixel against the current triangle.
  function automatic shaded_pixel_t shade_pixel(input coord_t px, input coord_t py);
    shaded_pixel_t res;
    longint        fx;
    longint        fy;
    longint        lo_x;
    longint        hi_x;
    longint        lo_y;
    longint        hi_y;
    longint        area;
    longint        den;
    longint        e;
    longint        level;
    longint        chan [3];
    int            area_sign;
    int            es;
    logic          covered;
    fx = px;
    fy = py;
    lo_x = vert_x[0];
    hi_x = vert_x[0];
    lo_y = vert_y[0];
    hi_y = vert_y[0];
    for (int i = 1; i < 3; i++) begin
      if (vert_x[i] < lo_x) lo_x = vert_x[i];
      if (vert_x[i] > hi_x) hi_x = vert_x[i];
      if (vert_y[i] < lo_y) lo_y = vert_y[i];
      if (vert_y[i] > hi_y) hi_y = vert_y[i];
    end
    area = edge_at(0, vert_x[0], vert_y[0]);
    area_sign = sign_of(area);
    den = (area < 0) ? -area : area;

    // A degenerate triangle or a pixel outside the half-open box is never drawn.
    covered = !(area_sign == 0 || fx < lo_x || fx >= hi_x || fy < lo_y || fy >= hi_y);

    for (int i = 0; i < 3; i++) begin
      chan[i] = 0;
      if (covered) begin
        e = edge_at(i, fx, fy);
        es = sign_of(e);
        if (es != 0 && es != area_sign) begin
          covered = 1'b0;
        end else if (es == 0) begin
          // Tie-break on a shared edge: keep it only when (-1,-1) is inside it.
          if (sign_of(edge_at(i, -1, -1)) != area_sign) covered = 1'b0;
        end else begin
          level = (255 * ((e < 0) ? -e : e)) / den;
          chan[i] = (level > 255) ? 255 : level;
        end
      end
    end

    res.x     = px;
    res.y     = py;
    res.drawn = covered;
    res.red   = covered ? COLOR_W'(chan[0]) : '0;
    res.green = covered ? COLOR_W'(chan[1]) : '0;
    res.blue  = covered ? COLOR_W'(chan[2]) : '0;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Predict on every accepted pixel word, compare on every accepted result word.
  always @(posedge clk) begin : track_words
    shaded_pixel_t want;
    if (!rst_n) begin
      expected_pixels.delete();
      pending_results <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_pixels.push_back(shade_pixel(in_pixel_x, in_pixel_y));
      end

      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_V0_X: vert_x[0] = cfg_wdata;
          REG_V0_Y: vert_y[0] = cfg_wdata;
          REG_V1_X: vert_x[1] = cfg_wdata;
          REG_V1_Y: vert_y[1] = cfg_wdata;
          REG_V2_X: vert_x[2] = cfg_wdata;
          REG_V2_Y: vert_y[2] = cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          $display("%0t: result word with no pixel waiting, actual x %0d y %0d",
                   $time, out_x, out_y);
        end else begin
          want = expected_pixels.pop_front();
          check_field("out_x", want.x, out_x);
          check_field("out_y", want.y, out_y);
          check_field("out_drawn", want.drawn, out_drawn);
          check_field("out_red", want.red, out_red);
          check_field("out_green", want.green, out_green);
          check_field("out_blue", want.blue, out_blue);
        end
      end

      pending_results <= expected_pixels.size();
    end
  end

  initial begin
    for (int i = 0; i < 3; i++) begin
      vert_x[i] = 0;
      vert_y[i] = 0;
    end
  end

endmodule

/* tb/triangle_barycentric_raster_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle barycentric rasterizer testbench
// Programs a series of triangles (directed corner cases first, then random
// small, large, extreme, axis-aligned and degenerate ones) and streams pixel
// words at each with random gaps (none in some passes), while the result
// side stalls at random. A side checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module triangle_barycentric_raster_tb;
  import tbr_pkg::*;

  localparam int RANDOM_TRIANGLES = 31;
  localparam int PIXELS_PER_TRI   = 50;
  localparam int BURST_TRIANGLE   = 3;
  localparam int HOLD_OFF_CYCLES  = 160;
  localparam int DRAIN_CYCLES     = 40;
  localparam int CYCLE_LIMIT      = 600_000;

  // Register indexes with no vertex behind them; writes there are dropped.
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG_HI = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  coord_t                cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  coord_t                in_pixel_x;
  coord_t                in_pixel_y;
  logic                  out_valid;
  logic                  out_stall;
  coord_t                out_x;
  coord_t                out_y;
  logic                  out_drawn;
  logic [COLOR_W-1:0]    out_red;
  logic [COLOR_W-1:0]    out_green;
  logic [COLOR_W-1:0]    out_blue;

  int     pending_results;
  int     mismatch_count;
  int     cycle_count;
  coord_t corner_x [3];
  coord_t corner_y [3];
  bit     burst_phase;
  bit     hold_off_done;
  bit     gapless;

  triangle_barycentric_raster dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pixel_x (in_pixel_x),
    .in_pixel_y (in_pixel_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_drawn  (out_drawn),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue)
  );

  pixel_coverage_checker u_coverage_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_drawn       (out_drawn),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .pending_results (pending_results),
    .mismatch_count  (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one pixel word after a random gap and hold it until it is taken.
  task automatic send_pixel(input coord_t px, input coord_t py);
    int r;
    int gap;
    r = $urandom_range(99);
    if (gapless || r < 60) gap = 0;
    else if (r < 85) gap = $urandom_range(3, 1);
    else if (r < 97) gap = $urandom_range(10, 4);
    else gap = $urandom_range(40, 15);
    if (gap != 0) begin
      in_valid   <= 1'b0;
      in_pixel_x <= coord_t'($urandom);
      in_pixel_y <= coord_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pixel_x <= px;
    in_pixel_y <= py;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending and wait until every pixel in flight has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Load a new triangle once the pipeline is empty.
  task automatic program_triangle(input coord_t ax, input coord_t ay, input coord_t bx,
                                  input coord_t by, input coord_t cx, input coord_t cy,
                                  input bit touch_unmapped);
    cfg_reg_t order [6];
    coord_t   vals [6];
    drain_results();
    order = '{REG_V0_X, REG_V0_Y, REG_V1_X, REG_V1_Y, REG_V2_X, REG_V2_Y};
    vals  = '{ax, ay, bx, by, cx, cy};
    corner_x = '{ax, bx, cx};
    corner_y = '{ay, by, cy};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= order[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    if (touch_unmapped) begin
      cfg_index <= UNMAPPED_REG_LO;
      cfg_wdata <= coord_t'($urandom);
      @(posedge clk);
      cfg_index <= UNMAPPED_REG_HI;
      cfg_wdata <= coord_t'($urandom);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic coord_t pick_extreme();
    int r;
    r = $urandom_range(2);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return coord_t'($urandom);
  endfunction

  // One random triangle and a stream of pixels mostly from its bounding box.
  task automatic random_triangle_pass(input int pass);
    coord_t t [6];
    coord_t lo_x;
    coord_t hi_x;
    coord_t lo_y;
    coord_t hi_y;
    coord_t px;
    coord_t py;
    int     mode;
    int     bx;
    int     by;
    int     dx;
    int     dy;
    int     r;
    int     k;
    mode = $urandom_range(9);
    if (mode <= 3) begin
      // Small triangles put many pixels exactly on an edge.
      bx = $urandom_range(1008);
      by = $urandom_range(1008);
      for (int i = 0; i < 3; i++) begin
        t[2*i]   = coord_t'(bx + $urandom_range(15));
        t[2*i+1] = coord_t'(by + $urandom_range(15));
      end
    end else if (mode <= 6) begin
      for (int i = 0; i < 6; i++) t[i] = coord_t'($urandom);
    end else if (mode == 7) begin
      for (int i = 0; i < 6; i++) t[i] = pick_extreme();
    end else if (mode == 8) begin
      // Collinear or coincident vertices give zero area.
      bx = $urandom_range(800);
      by = $urandom_range(800);
      dx = $urandom_range(1) ? $urandom_range(100) : 0;
      dy = $urandom_range(1) ? $urandom_range(100) : 0;
      t = '{coord_t'(bx), coord_t'(by), coord_t'(bx + dx), coord_t'(by + dy),
            coord_t'(bx + 2*dx), coord_t'(by + 2*dy)};
    end else begin
      // Right triangle with axis-aligned legs, either winding.
      bx = $urandom_range(1023);
      by = $urandom_range(1023);
      dx = $urandom_range(1023);
      dy = $urandom_range(1023);
      if ($urandom_range(1))
        t = '{coord_t'(bx), coord_t'(by), coord_t'(dx), coord_t'(by), coord_t'(bx), coord_t'(dy)};
      else
        t = '{coord_t'(bx), coord_t'(by), coord_t'(bx), coord_t'(dy), coord_t'(dx), coord_t'(by)};
    end

    program_triangle(t[0], t[1], t[2], t[3], t[4], t[5], $urandom_range(4) == 0);
    burst_phase = (pass == BURST_TRIANGLE);
    gapless = burst_phase || (pass % 4 == 1);

    lo_x = corner_x[0];
    hi_x = corner_x[0];
    lo_y = corner_y[0];
    hi_y = corner_y[0];
    for (int i = 1; i < 3; i++) begin
      if (corner_x[i] < lo_x) lo_x = corner_x[i];
      if (corner_x[i] > hi_x) hi_x = corner_x[i];
      if (corner_y[i] < lo_y) lo_y = corner_y[i];
      if (corner_y[i] > hi_y) hi_y = corner_y[i];
    end

    for (int n = 0; n < PIXELS_PER_TRI; n++) begin
      r = $urandom_range(99);
      if (r < 75) begin
        px = coord_t'($urandom_range(hi_x, lo_x));
        py = coord_t'($urandom_range(hi_y, lo_y));
      end else if (r < 85) begin
        k  = $urandom_range(2);
        px = corner_x[k];
        py = corner_y[k];
      end else if (r < 95) begin
        px = coord_t'($urandom);
        py = coord_t'($urandom);
      end else begin
        px = $urandom_range(1) ? '1 : '0;
        py = $urandom_range(1) ? '1 : '0;
      end
      send_pixel(px, py);
    end
    burst_phase = 1'b0;
  endtask

  // Result side: random stalls, stretches of none, and one long hold-off.
  // A random stretch is cut short as soon as the burst triangle starts, so the
  // long hold-off lands while that burst is still being offered.
  initial begin : result_stall
    int   r;
    int   span;
    logic level;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (burst_phase && !hold_off_done) begin
        level = 1'b1;
        span = HOLD_OFF_CYCLES;
        hold_off_done = 1'b1;
      end else begin
        r = $urandom_range(99);
        if (r < 55) begin
          level = 1'b0;
          span = $urandom_range(20, 1);
        end else if (r < 90) begin
          level = 1'b1;
          span = $urandom_range(4, 1);
        end else if (r < 97) begin
          level = 1'b0;
          span = $urandom_range(60, 20);
        end else begin
          level = 1'b1;
          span = $urandom_range(40, 10);
        end
      end
      out_stall <= level;
      repeat (span) begin
        if (burst_phase && !hold_off_done) break;
        @(posedge clk);
      end
    end
  end

  // Watchdog on the whole run.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    burst_phase   = 1'b0;
    hold_off_done = 1'b0;
    gapless       = 1'b0;
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_V0_X;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    in_pixel_x <= '0;
    in_pixel_y <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // All vertices at the origin after reset: zero area.
    send_pixel('0, '0);
    send_pixel('1, '1);

    // Large right triangle, positive winding: vertices, shared edges, box limits.
    program_triangle('0, '0, '1, '0, '0, '1, 1'b0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1, 10'd1);
    send_pixel(10'd1022, 10'd0);
    send_pixel(10'd511, 10'd512);
    send_pixel(10'd1022, 10'd1);
    send_pixel(10'd0, 10'd5);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd1, 10'd1022);
    send_pixel(10'd341, 10'd341);

    // Same triangle again with writes to the unmapped indexes.
    program_triangle('0, '0, '1, '0, '0, '1, 1'b1);
    send_pixel(10'd1, 10'd1);
    send_pixel(10'd600, 10'd600);

    // Opposite winding.
    program_triangle('0, '0, '0, '1, '1, '0, 1'b0);
    send_pixel(10'd1, 10'd1);
    send_pixel(10'd511, 10'd512);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1022, 10'd1);

    // Collinear vertices.
    program_triangle(10'd0, 10'd0, 10'd100, 10'd100, 10'd200, 10'd200, 1'b0);
    send_pixel(10'd50, 10'd50);
    send_pixel(10'd150, 10'd150);
    send_pixel(10'd10, 10'd0);

    // Triangle in the far corner of the coordinate space.
    program_triangle('1, '1, '0, '1, '1, '0, 1'b0);
    send_pixel(10'd1022, 10'd1022);
    send_pixel(10'd512, 10'd511);
    send_pixel(10'd1022, 10'd1);

    for (int pass = 0; pass < RANDOM_TRIANGLES; pass++) begin
      random_triangle_pass(pass);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* triangle_barycentric_raster.f */
hw/rtl/tbr_pkg.sv
hw/rtl/triangle_barycentric_raster.sv
tb/pixel_coverage_checker.sv
tb/triangle_barycentric_raster_tb.sv
